@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/icp_pkg.sv @@
// Package with types, codes and constants of the instruction class profiler.
`default_nettype none
package icp_pkg;
  localparam int unsigned ClassEntries = 64;
  localparam int unsigned IndivEntries = 64;
  localparam int unsigned CountWidth   = 48;

  localparam logic [1:0] ReqWrite    = 2'd0;
  localparam logic [1:0] ReqCount    = 2'd1;
  localparam logic [1:0] ReqReadCls  = 2'd2;
  localparam logic [1:0] ReqReadInd  = 2'd3;

  localparam logic [1:0] ModeClass = 2'd0;
  localparam logic [1:0] ModeIndiv = 2'd1;
  localparam logic [1:0] ModeNone  = 2'd2;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatRange = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  entry_index;
    logic [31:0] match_mask;
    logic [31:0] match_pattern;
    logic [1:0]  count_mode;
    logic [31:0] opcode_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  class_index;
    logic [1:0]  class_mode;
    logic        counted;
    logic [47:0] hit_count;
    logic [31:0] entry_opcode;
    logic        entry_valid;
  } rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StWrite,
    StOut
  } state_e;
endpackage
`default_nettype wire

@@ design/icp_req_if.sv @@
// Valid/ready channels carrying requests and responses.
`default_nettype none
interface icp_req_if;
  import icp_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface icp_rsp_if;
  import icp_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/icp_match.sv @@
// Priority ternary match over the class table registers.
`default_nettype none
module icp_match #(
  parameter int unsigned CLASS_ENTRIES = icp_pkg::ClassEntries,
  localparam int unsigned CW = $clog2(CLASS_ENTRIES)
) (
  input  wire logic [CLASS_ENTRIES-1:0][31:0] masks_i,
  input  wire logic [CLASS_ENTRIES-1:0][31:0] patterns_i,
  input  wire logic [CW:0]                    active_n_i,
  input  wire logic [31:0]                    word_i,
  output      logic [CW-1:0]                  hit_o
);
  import icp_pkg::*;
  logic [CLASS_ENTRIES-1:0] match;

  // Compare every in-use entry in parallel.
  always_comb begin
    for (int i = 0; i < CLASS_ENTRIES; i++) begin
      match[i] = ((word_i & masks_i[i]) == patterns_i[i]) && (i < 32'(active_n_i));
    end
  end

  // Lowest matching index wins; the last in-use entry is the fallback.
  always_comb begin
    logic found;
    found = 1'b0;
    hit_o = CW'(active_n_i - 1'b1);
    for (int i = 0; i < CLASS_ENTRIES; i++) begin
      if (match[i] && !found) begin
        hit_o = CW'(i);
        found = 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/instruction_class_profiler_top.sv @@
// Top level of the instruction class profiler.
// Channel   | Dir | Payload
// req       | in  | req_type, entry_index, match_mask, match_pattern, count_mode, opcode_word
// rsp       | out | status, class_index, class_mode, counted, hit_count, entry_opcode, entry_valid
// cfg       | in  | active_entries (write enable, data)
// After acceptance a request passes the read state (counter memory read), the write state
// (write back and result register load) and the out state; one request is in flight at a time.
// The counter memories have one read and one write port each.
// Reset clears table, valid bits and fill count at once; no clearing pass.
// A new request is taken only once the result register is empty, so a stalled result
// holds off the input.
`default_nettype none
module instruction_class_profiler_top #(
  parameter int unsigned CLASS_ENTRIES = icp_pkg::ClassEntries,
  parameter int unsigned INDIV_ENTRIES = icp_pkg::IndivEntries,
  parameter int unsigned COUNT_WIDTH   = icp_pkg::CountWidth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  icp_req_if.sink         req,
  icp_rsp_if.source       rsp,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i
);
  import icp_pkg::*;
  localparam int unsigned CW = $clog2(CLASS_ENTRIES);
  localparam int unsigned IW = (INDIV_ENTRIES > 1) ? $clog2(INDIV_ENTRIES) : 1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_valid_q;
  logic [6:0] active_q;
  logic [CW:0] active_n;

  logic [CLASS_ENTRIES-1:0][31:0] masks_q, pats_q;
  logic [CLASS_ENTRIES-1:0][1:0]  modes_q;
  logic [CLASS_ENTRIES-1:0]       ccnt_ok_q;
  logic [INDIV_ENTRIES-1:0]       ivalid_q;
  logic [INDIV_ENTRIES-1:0][31:0] iops_q;
  logic [IW:0]                    fill_q;

  // Class counters in one memory; per-opcode class and count share the other.
  logic [COUNT_WIDTH-1:0]    ccnt_mem [CLASS_ENTRIES];
  logic [CW+COUNT_WIDTH-1:0] ind_mem [INDIV_ENTRIES];
  logic [COUNT_WIDTH-1:0]    ccnt_rd_q;
  logic [CW+COUNT_WIDTH-1:0] ind_rd_q;
  logic [COUNT_WIDTH-1:0]    icnt_rd;
  logic [CW-1:0]             icls_rd;

  logic [CW-1:0] hit;
  logic [CW-1:0] hit_q;
  logic [IW-1:0] slot_q;
  logic          slot_found_q, slot_new_q;

  assign icnt_rd = ind_rd_q[COUNT_WIDTH-1:0];
  assign icls_rd = ind_rd_q[CW+COUNT_WIDTH-1:COUNT_WIDTH];

  // Effective entry count.
  always_comb begin
    if (active_q == '0) active_n = (CW+1)'(1);
    else if (32'(active_q) > CLASS_ENTRIES) active_n = (CW+1)'(CLASS_ENTRIES);
    else active_n = (CW+1)'(active_q);
  end

  icp_match #(.CLASS_ENTRIES(CLASS_ENTRIES)) u_match (
    .masks_i(masks_q), .patterns_i(pats_q), .active_n_i(active_n),
    .word_i(req.payload.opcode_word), .hit_o(hit)
  );

  assign req.ready = (state_q == StIdle) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  // Opcode lookup in the per-opcode store, done on acceptance.
  logic          find_ok;
  logic [IW-1:0] find_slot;
  always_comb begin
    find_ok = 1'b0;
    find_slot = '0;
    for (int s = 0; s < INDIV_ENTRIES; s++) begin
      if (ivalid_q[s] && iops_q[s] == req.payload.opcode_word && !find_ok) begin
        find_ok = 1'b1;
        find_slot = IW'(s);
      end
    end
  end

  logic accept;
  assign accept = req.valid && req.ready;
  logic [CW-1:0] cls_idx;
  assign cls_idx = (req.payload.req_type == ReqCount) ? hit : CW'(req.payload.entry_index);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StRead;
      StRead:  state_d = StWrite;
      StWrite: state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Result computation in the write-back cycle.
  logic [COUNT_WIDTH-1:0] cval, ival, cinc, iinc;
  logic [1:0] m;
  logic idx_ok_cls, idx_ok_ind;
  always_comb begin
    cval = ccnt_ok_q[hit_q] ? ccnt_rd_q : '0;
    ival = slot_new_q ? '0 : icnt_rd;
    cinc = (cval == CountMax) ? CountMax : cval + 1'b1;
    iinc = (ival == CountMax) ? CountMax : ival + 1'b1;
    m = modes_q[hit_q];
    idx_ok_cls = 32'(req_q.entry_index) < 32'(active_n);
    idx_ok_ind = 32'(req_q.entry_index) < INDIV_ENTRIES;
    rsp_d = '0;
    case (req_q.req_type)
      ReqWrite: begin
        if (32'(req_q.entry_index) >= CLASS_ENTRIES) rsp_d.status = StatRange;
        else begin
          rsp_d.class_index = req_q.entry_index;
          rsp_d.class_mode = m;
        end
      end
      ReqCount: begin
        rsp_d.class_index = 6'(hit_q);
        rsp_d.class_mode = m;
        if (m == ModeClass) begin
          rsp_d.counted = 1'b1;
          rsp_d.hit_count = 48'(cinc);
        end else if (m == ModeIndiv) begin
          if (slot_found_q) begin
            rsp_d.counted = 1'b1;
            rsp_d.hit_count = 48'(iinc);
          end else rsp_d.status = StatFull;
        end
      end
      ReqReadCls: begin
        if (!idx_ok_cls) rsp_d.status = StatRange;
        else begin
          rsp_d.class_index = req_q.entry_index;
          rsp_d.class_mode = m;
          rsp_d.hit_count = 48'(cval);
        end
      end
      default: begin
        if (!idx_ok_ind) rsp_d.status = StatRange;
        else if (ivalid_q[slot_q]) begin
          rsp_d.class_index = 6'(icls_rd);
          rsp_d.class_mode = modes_q[icls_rd];
          rsp_d.hit_count = 48'(icnt_rd);
          rsp_d.entry_opcode = iops_q[slot_q];
          rsp_d.entry_valid = 1'b1;
        end
      end
    endcase
  end

  // Control registers and the class table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rsp_valid_q <= 1'b0;
      active_q <= 7'd1;
      masks_q <= '0;
      pats_q <= '0;
      modes_q <= '0;
      ccnt_ok_q <= '0;
      ivalid_q <= '0;
      iops_q <= '0;
      fill_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) active_q <= cfg_wdata_i;
      if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
      if (state_q == StWrite) rsp_valid_q <= 1'b1;
      if (state_q == StWrite) begin
        if (req_q.req_type == ReqWrite && 32'(req_q.entry_index) < CLASS_ENTRIES) begin
          ccnt_ok_q[hit_q] <= 1'b0;
        end
        if (req_q.req_type == ReqCount && m == ModeClass) ccnt_ok_q[hit_q] <= 1'b1;
        // A new opcode takes a slot only while the store has room.
        if (req_q.req_type == ReqCount && m == ModeIndiv && slot_new_q && slot_found_q) begin
          ivalid_q[slot_q] <= 1'b1;
          iops_q[slot_q] <= req_q.opcode_word;
          fill_q <= fill_q + 1'b1;
        end
      end
      if (accept && req.payload.req_type == ReqWrite &&
          32'(req.payload.entry_index) < CLASS_ENTRIES) begin
        masks_q[cls_idx] <= req.payload.match_mask;
        pats_q[cls_idx] <= req.payload.match_pattern;
        modes_q[cls_idx] <= (req.payload.count_mode == 2'd3) ? ModeNone
                                                              : req.payload.count_mode;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req.payload;
      hit_q <= cls_idx;
      if (req.payload.req_type == ReqReadInd) begin
        slot_q <= IW'(req.payload.entry_index);
        slot_found_q <= 1'b1;
        slot_new_q <= 1'b0;
      end else begin
        slot_q <= find_ok ? find_slot : IW'(fill_q);
        slot_found_q <= find_ok || (32'(fill_q) < INDIV_ENTRIES);
        slot_new_q <= !find_ok;
      end
    end
    if (state_q == StWrite) rsp_q <= rsp_d;
  end

  // Counter memories: read in the read state, written back in the following write state.
  always_ff @(posedge clk_i) begin
    if (state_q == StRead) begin
      ccnt_rd_q <= ccnt_mem[hit_q];
      ind_rd_q <= ind_mem[slot_q];
    end
    if (state_q == StWrite && req_q.req_type == ReqCount) begin
      if (m == ModeClass) ccnt_mem[hit_q] <= cinc;
      if (m == ModeIndiv && slot_found_q) begin
        ind_mem[slot_q] <= {(slot_new_q ? hit_q : icls_rd), iinc};
      end
    end
  end
endmodule
`default_nettype wire

@@ design/icp_checker.sv @@
// Port-level checker for the profiler, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module icp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic        rsp_counted,
  input wire logic        rsp_entry_valid
);
  import icp_pkg::*;
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, req_valid && req_ready, !req_ready)
  `ASSERT_IMPL(a_busy_out, clk_i, rst_ni, rsp_valid, !req_ready)
  `ASSERT_IMPL(a_count_ok, clk_i, rst_ni, rsp_valid && rsp_counted, rsp_status == StatOk)
  `ASSERT_IMPL(a_ev_no_count, clk_i, rst_ni, rsp_valid && rsp_entry_valid, !rsp_counted)
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind instruction_class_profiler_top icp_checker u_icp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.payload.status), .rsp_counted(rsp.payload.counted),
  .rsp_entry_valid(rsp.payload.entry_valid)
);
`default_nettype wire
